// ===== hdl/kfl_pkg.sv =====
// Package with shared types and constants for the keyframe interpolation unit.
`timescale 1ns / 1ps
package kfl_pkg;
  localparam int unsigned MaxKeysDefault = 64;
  localparam int unsigned TimeW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned CountW = 7;

  typedef enum logic [3:0] {
    StIdle,
    StScan,
    StScanWait,
    StLoadA,
    StLoadB,
    StLoadWait,
    StDiv,
    StMul,
    StMulWait,
    StDone
  } state_e;

  // Request to the divider.
  typedef struct packed {
    logic        start;
    logic [33:0] num_mag;
    logic        num_neg;
    logic [32:0] den_mag;
    logic        den_neg;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic signed [63:0] quot;
  } div_rsp_t;
endpackage

// ===== hdl/keyframe_vec3_lerp_unit.sv =====
// Top level of the keyframe vector interpolation unit.
`timescale 1ns / 1ps
// Keyframe linear interpolation of an (x, y, z) vector. A beat with action 0
// writes one key (time and value) into the key table and gives no result; a
// beat with action 1 queries at query_time and gives exactly one result,
// shown for one cycle with out_valid_o high. The receiver cannot stall, so
// capture results on the strobe. Keys live in one synchronous memory; a query
// scans it linearly, one key per pair of read-wait and compare states, then
// runs a serial divider with a 50-bit quotient for the interpolation factor
// and a two-pass multiplier per component. After the accepting edge busy
// stays high through the done state on a load; on a query it stays high
// through the scan, the key reads, the divider and the multipliers. When no
// segment is found, segment zero is used. A zero span or a single key skips
// the divider and the multipliers. The result beat appears in the cycle in
// which busy drops. key_count is written through the cfg channel only while
// busy is low; slots a query reads must have been loaded first.
module keyframe_vec3_lerp_unit #(
  parameter int unsigned MaxKeys = kfl_pkg::MaxKeysDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [5:0]  key_index_i,
  input  logic [31:0] key_time_i,
  input  logic signed [31:0] key_x_i,
  input  logic signed [31:0] key_y_i,
  input  logic signed [31:0] key_z_i,
  input  logic [31:0] query_time_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_key_count_i,
  output logic        out_valid_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic        no_segment_o,
  output logic        zero_span_o
);
  localparam int unsigned AddrW = $clog2(MaxKeys);
  localparam int unsigned CntW = AddrW + 1;

  kfl_pkg::state_e state_q, state_d;
  logic [6:0]  key_count_q;
  logic [31:0] qt_q;
  logic [CntW-1:0] n_q, idx_q, idx_d;
  logic [CntW-1:0] seg_q;
  logic        found_q;
  logic [127:0] rdata, a_q;
  logic [AddrW-1:0] raddr;
  logic        mem_we;
  logic [AddrW-1:0] waddr;
  kfl_pkg::div_req_t dreq;
  kfl_pkg::div_rsp_t drsp;
  logic        mul_start, mdone_x, mdone_y, mdone_z;
  logic signed [31:0] rx, ry, rz;
  logic [CntW-1:0] n_clamp;

  assign n_clamp = (32'(key_count_q) > MaxKeys) ? CntW'(MaxKeys) : CntW'(key_count_q);

  // Memory word: time in the top 32 bits, then x, y, z.
  assign mem_we = start && !busy && !action_i && (32'(key_index_i) < MaxKeys);
  assign waddr  = AddrW'(key_index_i);

  kfl_key_mem #(.MaxKeys(MaxKeys)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i ({key_time_i, key_x_i, key_y_i, key_z_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Scan reads slot idx+1; then slot seg, then slot seg+1.
  always_comb begin
    unique case (state_q)
      kfl_pkg::StScan, kfl_pkg::StScanWait: raddr = AddrW'(idx_q + CntW'(1));
      kfl_pkg::StLoadA: raddr = AddrW'(seg_q);
      default: raddr = AddrW'(seg_q + CntW'(1));
    endcase
  end

  logic [31:0] t0, t1;
  logic [33:0] num;
  logic [32:0] den;
  assign t0  = a_q[127:96];
  assign t1  = rdata[127:96];
  assign num = {2'b0, qt_q} - {2'b0, t0};
  assign den = {1'b0, t1} - {1'b0, t0};

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      kfl_pkg::StIdle: begin
        if (start && action_i) state_d = kfl_pkg::StScanWait;
        else if (start) state_d = kfl_pkg::StDone;
        idx_d = '0;
      end
      kfl_pkg::StScanWait: state_d = kfl_pkg::StScan;
      kfl_pkg::StScan: begin
        if (qt_q < rdata[127:96] || idx_q + CntW'(2) >= n_q) begin
          state_d = kfl_pkg::StLoadA;
        end else begin
          idx_d = idx_q + CntW'(1);
          state_d = kfl_pkg::StScanWait;
        end
      end
      kfl_pkg::StLoadA: state_d = kfl_pkg::StLoadB;
      kfl_pkg::StLoadB: state_d = kfl_pkg::StLoadWait;
      kfl_pkg::StLoadWait: begin
        if (n_q <= CntW'(1) || den == 33'd0) state_d = kfl_pkg::StDone;
        else state_d = kfl_pkg::StDiv;
      end
      kfl_pkg::StDiv: if (drsp.done) state_d = kfl_pkg::StMul;
      kfl_pkg::StMul: state_d = kfl_pkg::StMulWait;
      kfl_pkg::StMulWait: if (mdone_x) state_d = kfl_pkg::StDone;
      kfl_pkg::StDone: state_d = kfl_pkg::StIdle;
      default: state_d = kfl_pkg::StIdle;
    endcase
  end

  // A zero span shows up as equal times; a den of zero skips the divider above.
  logic zero_q, nores_q;
  logic [127:0] b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kfl_pkg::StIdle;
      key_count_q <= 7'd1;
      idx_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (cfg_valid_i && cfg_ready_o) key_count_q <= cfg_key_count_i;
      out_valid_o <= (state_q == kfl_pkg::StDone) && !nores_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == kfl_pkg::StIdle) begin
      qt_q    <= query_time_i;
      n_q     <= n_clamp;
      nores_q <= !action_i;
      found_q <= 1'b0;
      seg_q   <= '0;
      zero_q  <= 1'b0;
    end
    if (state_q == kfl_pkg::StScan) begin
      if (qt_q < rdata[127:96]) begin
        found_q <= 1'b1;
        seg_q   <= idx_q;
      end
    end
    if (state_q == kfl_pkg::StLoadB) a_q <= rdata;
    if (state_q == kfl_pkg::StLoadWait) begin
      b_q <= rdata;
      zero_q <= (n_q > CntW'(1)) && (den == 33'd0);
    end
    if (state_q == kfl_pkg::StDone) begin
      out_x_o      <= (state_q == kfl_pkg::StDone && !zero_q && n_q > CntW'(1))
                      ? rx : a_q[95:64];
      out_y_o      <= (!zero_q && n_q > CntW'(1)) ? ry : a_q[63:32];
      out_z_o      <= (!zero_q && n_q > CntW'(1)) ? rz : a_q[31:0];
      no_segment_o <= !found_q && n_q > CntW'(1);
      zero_span_o  <= zero_q;
    end
  end

  // The zero-span flag is registered, so the divider start tests den directly.
  always_comb begin
    dreq.start   = (state_q == kfl_pkg::StLoadWait) && n_q > CntW'(1) && den != 33'd0;
    dreq.num_neg = num[33];
    dreq.num_mag = num[33] ? 34'(-num) : num;
    dreq.den_neg = den[32];
    dreq.den_mag = den[32] ? 33'(-den) : den;
  end

  kfl_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  assign mul_start = (state_q == kfl_pkg::StMul);

  kfl_lerp u_lx (.clk_i(clk_i), .rst_ni(rst_ni), .start_i(mul_start),
    .factor_i(drsp.quot), .start_val_i(a_q[95:64]), .end_val_i(b_q[95:64]),
    .done_o(mdone_x), .result_o(rx));
  kfl_lerp u_ly (.clk_i(clk_i), .rst_ni(rst_ni), .start_i(mul_start),
    .factor_i(drsp.quot), .start_val_i(a_q[63:32]), .end_val_i(b_q[63:32]),
    .done_o(mdone_y), .result_o(ry));
  kfl_lerp u_lz (.clk_i(clk_i), .rst_ni(rst_ni), .start_i(mul_start),
    .factor_i(drsp.quot), .start_val_i(a_q[31:0]), .end_val_i(b_q[31:0]),
    .done_o(mdone_z), .result_o(rz));

  logic unused_done;
  assign unused_done = mdone_y ^ mdone_z ^ drsp.busy;

  assign busy        = (state_q != kfl_pkg::StIdle) || unused_done & 1'b0;
  assign cfg_ready_o = (state_q == kfl_pkg::StIdle);
endmodule

// ===== hdl/kfl_key_mem.sv =====
// Key table memory: times and values, one write port and one registered read port.
`timescale 1ns / 1ps
module kfl_key_mem #(
  parameter int unsigned MaxKeys = kfl_pkg::MaxKeysDefault,
  localparam int unsigned AddrW = $clog2(MaxKeys)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [127:0]     wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [127:0]     rdata_o
);
  logic [127:0] mem [MaxKeys];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== hdl/kfl_div.sv =====
// Restoring serial divider producing a signed 64-bit quotient truncated toward zero.
`timescale 1ns / 1ps
module kfl_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kfl_pkg::div_req_t req_i,
  output kfl_pkg::div_rsp_t rsp_o
);
  // Numerator magnitude times 65536 fits in 50 bits.
  logic [49:0] quo_q, quo_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] den_q;
  logic        neg_q, busy_q, busy_d, done_q;
  logic [5:0]  cnt_q, cnt_d;
  logic [33:0] trial;
  logic [34:0] diff;

  always_comb begin
    trial  = {rem_q[32:0], quo_q[49]};
    diff   = {1'b0, trial} - {2'b00, den_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (busy_q) begin
      if (!diff[34]) begin
        rem_d = diff[33:0];
        quo_d = {quo_q[48:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[48:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !busy_d;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd50;
      end else begin
        busy_q <= busy_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= {req_i.num_mag[33:0], 16'h0};
      rem_q <= '0;
      den_q <= req_i.den_mag;
      neg_q <= req_i.num_neg ^ req_i.den_neg;
    end else begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -$signed({14'h0, quo_q}) : $signed({14'h0, quo_q});
endmodule

// ===== hdl/kfl_lerp.sv =====
// Per-component interpolation: partial products, floor shift, add and saturate.
`timescale 1ns / 1ps
module kfl_lerp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic signed [63:0] factor_i,
  input  logic signed [31:0] start_val_i,
  input  logic signed [31:0] end_val_i,
  output logic        done_o,
  output logic signed [31:0] result_o
);
  // Factor magnitude is at most 2^49; delta magnitude at most 2^32.
  logic [49:0] a_q;
  logic [32:0] b_q;
  logic        neg_q;
  logic signed [31:0] s_q;
  logic [1:0]  ph_q;
  logic [82:0] acc_q;
  logic [24:0] a_part;
  logic [57:0] pp;
  logic signed [32:0] delta;
  logic [63:0] fmag;
  logic [66:0] qv;
  logic [66:0] qr;
  logic signed [42:0] qmag;
  logic signed [42:0] sum;

  assign delta = 33'(end_val_i) - 33'(start_val_i);
  assign fmag  = factor_i[63] ? 64'(-factor_i) : 64'(factor_i);
  assign a_part = a_q[24:0];
  assign pp = a_part * b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        ph_q <= 2'd1;
      end else if (ph_q == 2'd1) begin
        ph_q <= 2'd2;
      end else if (ph_q == 2'd2) begin
        ph_q <= 2'd3;
      end else if (ph_q == 2'd3) begin
        ph_q   <= 2'd0;
        done_o <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= fmag[49:0];
      b_q   <= delta[32] ? 33'(-delta) : 33'(delta);
      neg_q <= (factor_i[63] != delta[32]) && (factor_i != 0) && (delta != 0);
      s_q   <= start_val_i;
      acc_q <= '0;
    end else if (ph_q == 2'd1) begin
      acc_q <= 83'(pp);
      a_q   <= {a_q[24:0], a_q[49:25]};
    end else if (ph_q == 2'd2) begin
      acc_q <= acc_q + {pp, 25'h0};
    end else if (ph_q == 2'd3) begin
      result_o <= (|qv[66:40]) ? (neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff)
                : (sum > 43'sd2147483647) ? 32'sh7fff_ffff
                : (sum < -43'sd2147483648) ? 32'sh8000_0000 : sum[31:0];
    end
  end

  // Phase one multiplies the low half (a_q rotated after), phase two the high half.
  assign qv   = acc_q[82:16];
  assign qr   = qv + 67'((neg_q && (acc_q[15:0] != 0)) ? 1 : 0);
  assign qmag = {2'b00, qr[40:0]};
  assign sum  = 43'(s_q) + (neg_q ? -qmag : qmag);
endmodule

// ===== tb/sv/tb_keyframe_vec3_lerp_unit.sv =====
// Self-checking testbench for the keyframe vector interpolation unit.
`timescale 1ns / 1ps
module tb_keyframe_vec3_lerp_unit;

  localparam int unsigned NumSlots = kfl_pkg::MaxKeysDefault;
  // A load gives no result; this much quiet time is enough for the block to settle.
  localparam int unsigned SettleCycles = 300;
  localparam int unsigned CycleLimit = 2000000;

  // Load and query codes carried on action_i.
  typedef enum logic {
    ActLoad  = 1'b0,
    ActQuery = 1'b1
  } action_e;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               no_seg;
    logic               zero_span;
  } lerp_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic action_i = 1'b0;
  logic [5:0] key_index_i = '0;
  logic [31:0] key_time_i = '0;
  logic signed [31:0] key_x_i = '0;
  logic signed [31:0] key_y_i = '0;
  logic signed [31:0] key_z_i = '0;
  logic [31:0] query_time_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [6:0] cfg_key_count_i = '0;
  logic out_valid_o;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic signed [31:0] out_z_o;
  logic no_segment_o;
  logic zero_span_o;

  keyframe_vec3_lerp_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .action_i(action_i), .key_index_i(key_index_i), .key_time_i(key_time_i),
    .key_x_i(key_x_i), .key_y_i(key_y_i), .key_z_i(key_z_i),
    .query_time_i(query_time_i), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_key_count_i(cfg_key_count_i),
    .out_valid_o(out_valid_o), .out_x_o(out_x_o), .out_y_o(out_y_o),
    .out_z_o(out_z_o), .no_segment_o(no_segment_o), .zero_span_o(zero_span_o)
  );

  always #1 clk_i = ~clk_i;

  // Our own copy of the key table and the key count register.
  logic [31:0] tbl_time [NumSlots];
  logic signed [31:0] tbl_val [NumSlots][3];
  logic [6:0] model_count = 7'd1;

  lerp_res_t pending_q[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned loads_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;

  // One component: start + floor(factor * (end - start) / 65536), saturated.
  function automatic logic signed [31:0] lerp_axis(logic signed [31:0] s_val,
                                                   logic signed [31:0] e_val,
                                                   longint factor);
    logic signed [127:0] delta;
    logic signed [127:0] prod;
    logic signed [127:0] sum;
    logic signed [127:0] f_wide;
    logic signed [31:0] hi_lim;
    logic signed [31:0] lo_lim;
    hi_lim = 32'sh7FFF_FFFF;
    lo_lim = 32'sh8000_0000;
    delta = e_val;
    delta = delta - s_val;
    f_wide = factor;
    prod = delta * f_wide;
    sum = s_val;
    sum = sum + (prod >>> 16);
    if (sum > hi_lim) return hi_lim;
    if (sum < lo_lim) return lo_lim;
    return sum[31:0];
  endfunction

  // Interpolated result of a query against the current table and count.
  function automatic lerp_res_t interp_query(logic [31:0] qt);
    lerp_res_t r;
    int unsigned n;
    int unsigned seg;
    bit found;
    longint num;
    longint den;
    longint factor;
    n = model_count;
    if (n > NumSlots) n = NumSlots;
    seg = 0;
    found = 1'b0;
    r.no_seg = 1'b0;
    r.zero_span = 1'b0;
    if (n <= 1) begin
      r.x = tbl_val[0][0];
      r.y = tbl_val[0][1];
      r.z = tbl_val[0][2];
      return r;
    end
    for (int i = 0; i + 1 < n; i++) begin
      if (!found && qt < tbl_time[i+1]) begin
        seg = i;
        found = 1'b1;
      end
    end
    r.no_seg = !found;
    num = longint'(qt) - longint'(tbl_time[seg]);
    den = longint'(tbl_time[seg+1]) - longint'(tbl_time[seg]);
    if (den == 0) begin
      r.zero_span = 1'b1;
      r.x = tbl_val[seg][0];
      r.y = tbl_val[seg][1];
      r.z = tbl_val[seg][2];
    end else begin
      factor = (num * 65536) / den;
      r.x = lerp_axis(tbl_val[seg][0], tbl_val[seg+1][0], factor);
      r.y = lerp_axis(tbl_val[seg][1], tbl_val[seg+1][1], factor);
      r.z = lerp_axis(tbl_val[seg][2], tbl_val[seg+1][2], factor);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
             results_seen);
    mismatches++;
  endtask

  // Results are sampled mid-cycle, well away from the edges that move them.
  always @(negedge clk_i) begin
    lerp_res_t w;
    if (rst_ni && out_valid_o) begin
      if (pending_q.size() == 0) begin
        $display("MISMATCH unexpected result beat: x %h y %h z %h", out_x_o,
                 out_y_o, out_z_o);
        mismatches++;
      end else begin
        w = pending_q.pop_front();
        if (out_x_o !== w.x) report_mismatch("out_x", out_x_o, w.x);
        if (out_y_o !== w.y) report_mismatch("out_y", out_y_o, w.y);
        if (out_z_o !== w.z) report_mismatch("out_z", out_z_o, w.z);
        if (no_segment_o !== w.no_seg)
          report_mismatch("no_segment", no_segment_o, w.no_seg);
        if (zero_span_o !== w.zero_span)
          report_mismatch("zero_span", zero_span_o, w.zero_span);
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sends one beat. Beats go in bursts; between most bursts start drops for
  // a random gap. The beat is taken at the rising edge after busy is seen low.
  task automatic send_item(action_e act, logic [5:0] idx, logic [31:0] kt,
                           logic signed [31:0] kx, logic signed [31:0] ky,
                           logic signed [31:0] kz, logic [31:0] qt);
    int unsigned gap;
    lerp_res_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start <= 1'b1;
    action_i <= act;
    key_index_i <= idx;
    key_time_i <= kt;
    key_x_i <= kx;
    key_y_i <= ky;
    key_z_i <= kz;
    query_time_i <= qt;
    forever begin
      @(negedge clk_i);
      if (!busy) begin
        @(posedge clk_i);
        break;
      end
      @(posedge clk_i);
    end
    // Accepted at this edge: update the table or queue the expected result.
    if (act == ActLoad) begin
      tbl_time[idx] = kt;
      tbl_val[idx][0] = kx;
      tbl_val[idx][1] = ky;
      tbl_val[idx][2] = kz;
      loads_sent++;
    end else begin
      r = interp_query(qt);
      pending_q = {pending_q, r};
      queries_sent++;
    end
  endtask

  task automatic load_key(int unsigned idx, logic [31:0] kt, logic signed [31:0] kx,
                          logic signed [31:0] ky, logic signed [31:0] kz);
    send_item(ActLoad, idx[5:0], kt, kx, ky, kz, $urandom);
  endtask

  task automatic query_at(logic [31:0] qt);
    send_item(ActQuery, 6'($urandom), $urandom, $urandom, $urandom, $urandom, qt);
  endtask

  // Holds the sender off until every expected result has come and the block
  // has had time to finish any load still in flight.
  task automatic drain_all();
    start <= 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_key_count(logic [6:0] cnt);
    drain_all();
    cfg_valid_i <= 1'b1;
    cfg_key_count_i <= cnt;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) begin
        @(posedge clk_i);
        break;
      end
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    model_count = cnt;
  endtask

  // Fills every slot with non-decreasing times; a small step keeps spans short.
  task automatic fill_table(int unsigned max_step);
    logic [31:0] t;
    t = $urandom_range(0, 1000);
    for (int unsigned i = 0; i < NumSlots; i++) begin
      load_key(i, t, $urandom, $urandom, $urandom);
      t = t + $urandom_range(0, max_step);
    end
  endtask

  // The whole table loaded, then queries with a key count of one and zero.
  task automatic test_single_key();
    fill_table(5000);
    query_at(32'h0);
    query_at(32'hFFFF_FFFF);
    write_key_count(7'd0);
    query_at($urandom);
    query_at(tbl_time[0]);
  endtask

  // Directed corner cases on a few hand-placed keys.
  task automatic test_directed();
    write_key_count(7'd64);
    // Full-range value swing so extrapolation saturates both ways.
    load_key(0, 32'd1000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000);
    load_key(1, 32'd1001, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF);
    query_at(32'd0);
    query_at(32'd1000);
    query_at(32'd1001);
    query_at(32'hFFFF_FFFF);
    // Past every key or before both, segment zero is used for extrapolation.
    write_key_count(7'd2);
    query_at(32'hFFFF_FFFF);
    query_at(32'd999);
    // Equal times give a zero span, both with a segment found and without.
    load_key(1, 32'd1000, 32'sh1234_5678, 32'sh8765_4321, 32'sh0000_FFFF);
    query_at(32'd500);
    query_at(32'd2000);
    // Wide span with ordinary interpolation, then a count above the table.
    load_key(1, 32'hFFFF_FFFF, 32'sh0001_0000, 32'sh7FFF_0000, 32'shC000_0000);
    query_at(32'h8000_0000);
    query_at(32'hFFFF_FFFE);
    write_key_count(7'd127);
    query_at(32'h0000_0001);
    query_at(32'hFFFF_FFFF);
  endtask

  // Random phases, each with its own key count. Queries mostly fall up to 20000
  // after a key time; some hit key times exactly, some are random or extremes.
  task automatic test_random(int unsigned phases, int unsigned per_phase);
    logic [6:0] cnt;
    logic [31:0] qt;
    int unsigned n;
    int unsigned pick;
    int unsigned slot;
    for (int unsigned p = 0; p < phases; p++) begin
      case ($urandom_range(0, 9))
        0: cnt = 7'($urandom_range(0, 1));
        1: cnt = 7'($urandom_range(65, 127));
        2: cnt = 7'd64;
        default: cnt = 7'($urandom_range(2, 64));
      endcase
      write_key_count(cnt);
      if ($urandom_range(0, 2) == 0) fill_table($urandom_range(0, 1) ? 3 : 32'h0300_0000);
      n = (cnt > NumSlots) ? NumSlots : ((cnt == 0) ? 1 : cnt);
      for (int unsigned k = 0; k < per_phase; k++) begin
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, n - 1);
        if (pick < 12) begin
          // Rewrite a key, usually keeping it near its old time.
          qt = ($urandom_range(0, 3) == 0) ? $urandom
                                            : tbl_time[slot] + $urandom_range(0, 8) - 4;
          load_key(slot, qt, $urandom, $urandom, $urandom);
        end else begin
          if (pick < 25) qt = tbl_time[slot];
          else if (pick < 32) qt = $urandom;
          else if (pick < 36) qt = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
          else qt = tbl_time[slot] + $urandom_range(0, 20000);
          query_at(qt);
        end
      end
      // Every so often the sender waits out all results at the end of a phase.
      if (p % 3 == 1) drain_all();
    end
  endtask

  initial begin
    for (int i = 0; i < NumSlots; i++) begin
      tbl_time[i] = '0;
      tbl_val[i][0] = '0;
      tbl_val[i][1] = '0;
      tbl_val[i][2] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_key();
    test_directed();
    test_random(10, 200);
    write_key_count(7'd64);
    query_at($urandom);
    drain_all();
    $display("Covered %0d loads and %0d queries, %0d results checked.",
             loads_sent, queries_sent, results_seen);
    $display("Key counts from zero to 127, saturation, zero spans and missing segments.");
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== keyframe_vec3_lerp_unit.f =====
hdl/kfl_pkg.sv
hdl/kfl_key_mem.sv
hdl/kfl_div.sv
hdl/kfl_lerp.sv
hdl/keyframe_vec3_lerp_unit.sv
tb/sv/tb_keyframe_vec3_lerp_unit.sv
